FILE: hdl/plid_pkg.sv
// plid_pkg: shared constants and types for the positional list block.
// Command and status codes, field widths, the cell update select.
// No dependencies.
package plid_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int POS_W         = 5;
  localparam int CNT_W         = 5;
  localparam int STAT_W        = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELPOS = 3'd2,
    CMD_DELVAL = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_POS  = 2'd2
  } status_e;

  // what a cell takes on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PREV = 2'd1,
    CELL_NEXT = 2'd2,
    CELL_LOAD = 2'd3
  } cell_op_e;

endpackage

FILE: hdl/plid_cell.sv
// plid_cell: one storage cell of the list chain.
// Holds one entry, or takes its lower neighbor, upper neighbor or the load bus.
// Depends on plid_pkg.
module plid_cell (
  input  logic                               clk_i,
  input  plid_pkg::cell_op_e                 op_i,
  input  logic signed [plid_pkg::DATA_W-1:0] prev_i,
  input  logic signed [plid_pkg::DATA_W-1:0] next_i,
  input  logic signed [plid_pkg::DATA_W-1:0] load_i,
  output logic signed [plid_pkg::DATA_W-1:0] data_o
);
  import plid_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD: data_d = data_q;
      CELL_PREV: data_d = prev_i;
      CELL_NEXT: data_d = next_i;
      CELL_LOAD: data_d = load_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: hdl/positional_list_insert_delete.sv
// positional_list_insert_delete: packed list of signed entries in a chain of cells.
// Command control, fill count and result registers; instantiates plid_cell.
// Depends on plid_pkg.
//
// Append, insert at position, delete at position, bad positions, a full list and
// unused command codes need no rotation: the result strobe done_o rises the
// cycle after start_i is taken, and busy_o stays low, so a command can be given
// every cycle. Delete by value and a good read rotate the cell chain once around
// the list, one entry per cycle, with busy_o high; done_o rises the cycle after
// the last entry is rotated (the cycle after the command when the list is
// empty). Each result is shown for exactly one cycle while done_o is high and
// must be taken then; count_o always shows the current fill count.
module positional_list_insert_delete #(
  parameter int DEPTH = plid_pkg::DEFAULT_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [plid_pkg::CMD_W-1:0]         command_i,
  input  logic [plid_pkg::POS_W-1:0]         position_i,
  input  logic signed [plid_pkg::DATA_W-1:0] value_i,
  output logic                               done_o,
  output logic signed [plid_pkg::DATA_W-1:0] read_data_o,
  output logic [plid_pkg::CNT_W-1:0]         count_o,
  output logic [plid_pkg::CNT_W-1:0]         removed_o,
  output logic [plid_pkg::STAT_W-1:0]        status_o
);
  import plid_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ROT  = 2'b10
  } state_e;

  typedef enum logic [2:0] {
    K_HOLD,
    K_APPEND,
    K_INSERT,
    K_DELPOS,
    K_KEEP,
    K_DROP
  } kind_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            total_q, total_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            removed_q, removed_d;
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic signed [DATA_W-1:0] rdata_q, rdata_d;
  status_e                  status_q, status_d;
  logic                     done_q, done_d;
  kind_e                    kind;

  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] load;
  logic [WW-1:0]            cnt_w, pos_w, posq_w, idx_w, total_w, rem_w;

  assign cnt_w   = WW'(count_q);
  assign pos_w   = WW'(position_i);
  assign posq_w  = WW'(pos_q);
  assign idx_w   = WW'(idx_q);
  assign total_w = WW'(total_q);
  assign rem_w   = WW'(removed_q);

  assign load = (state_q == S_ROT) ? cell_q[0] : value_i;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    total_d   = total_q;
    idx_d     = idx_q;
    removed_d = removed_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    value_d   = value_q;
    rdata_d   = rdata_q;
    status_d  = status_q;
    done_d    = 1'b0;
    kind      = K_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d     = command_i;
          pos_d     = position_i;
          value_d   = value_i;
          rdata_d   = '0;
          removed_d = '0;
          status_d  = ST_OK;
          total_d   = count_q;
          idx_d     = '0;
          unique case (command_i)
            CMD_APPEND: begin
              done_d = 1'b1;
              if (cnt_w >= DEPTH_W) begin
                status_d = ST_FULL;
              end else begin
                kind    = K_APPEND;
                count_d = count_q + CW'(1);
              end
            end
            CMD_INSERT: begin
              done_d = 1'b1;
              if (cnt_w >= DEPTH_W) begin
                status_d = ST_FULL;
              end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
                status_d = ST_POS;
              end else begin
                kind    = K_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            CMD_DELPOS: begin
              done_d = 1'b1;
              if (pos_w == '0 || pos_w > cnt_w) begin
                status_d = ST_POS;
              end else begin
                kind      = K_DELPOS;
                count_d   = count_q - CW'(1);
                removed_d = CW'(1);
              end
            end
            CMD_DELVAL: begin
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = S_ROT;
              end
            end
            CMD_READ: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                status_d = ST_POS;
                done_d   = 1'b1;
              end else begin
                state_d = S_ROT;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_ROT: begin
        if (cmd_q == CMD_DELVAL && cell_q[0] == value_q) begin
          kind      = K_DROP;
          count_d   = count_q - CW'(1);
          removed_d = removed_q + CW'(1);
        end else begin
          kind = K_KEEP;
        end
        if (cmd_q == CMD_READ && idx_w + WW'(1) == posq_w) begin
          rdata_d = cell_q[0];
        end
        idx_d = idx_q + CW'(1);
        if (idx_w + WW'(1) == total_w) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [WW-1:0] II = WW'(i);
    cell_op_e                 op;
    logic signed [DATA_W-1:0] prev, next;

    assign prev = (i == 0) ? cell_q[i] : cell_q[(i == 0) ? 0 : i - 1];
    assign next = (i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1];

    always_comb begin
      unique case (kind)
        K_HOLD:   op = CELL_HOLD;
        K_APPEND: op = (II == cnt_w) ? CELL_LOAD : CELL_HOLD;
        K_INSERT: begin
          if (II + WW'(1) == pos_w) begin
            op = CELL_LOAD;
          end else if (II >= pos_w) begin
            op = CELL_PREV;
          end else begin
            op = CELL_HOLD;
          end
        end
        K_DELPOS: op = (II + WW'(1) >= pos_w) ? CELL_NEXT : CELL_HOLD;
        K_KEEP: begin
          if (II + WW'(1) == cnt_w) begin
            op = CELL_LOAD;
          end else if (II + WW'(1) < cnt_w) begin
            op = CELL_NEXT;
          end else begin
            op = CELL_HOLD;
          end
        end
        K_DROP:   op = CELL_NEXT;
        default:  op = CELL_HOLD;
      endcase
    end

    plid_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .prev_i (prev),
      .next_i (next),
      .load_i (load),
      .data_o (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      done_q    <= 1'b0;
      idx_q     <= '0;
      total_q   <= '0;
      removed_q <= '0;
      status_q  <= ST_OK;
      cmd_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      done_q    <= done_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      removed_q <= removed_d;
      status_q  <= status_d;
      cmd_q     <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    value_q <= value_d;
    rdata_q <= rdata_d;
  end

  assign busy_o      = (state_q == S_ROT);
  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign count_o     = cnt_w[CNT_W-1:0];
  assign removed_o   = rem_w[CNT_W-1:0];
  assign status_o    = status_q;

  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (cnt_w == DEPTH_W))
    else $error("full status with list not at depth");

  a_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != CMD_DELVAL && command_i != CMD_READ) |=> done_o)
    else $error("single-cycle command gave no result");

  a_rot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (rem_w + cnt_w == total_w))
    else $error("removed plus count differs from starting count");

  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result strobe while rotating");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= DEPTH_W)
    else $error("fill count above depth");

endmodule
